[src/drt_pkg.sv]
// Shared constants, codes and types of the dual reload timer register block.
package drt_pkg;

	localparam int COUNTER_BITS = 32;
	localparam int TIMER_COUNT  = 2;
	localparam int TIMER_SLOTS  = 2;

	localparam int DATA_W     = 32;
	localparam int S_TDATA_W  = 40;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 40;
	localparam int IDX_W      = 4;
	localparam int CTRL_W     = 8;
	localparam int PSC_W      = 7;

	localparam int CTL_EN_BIT     = 0;
	localparam int CTL_RELOAD_BIT = 1;
	localparam int CTL_DIV_LO     = 4;
	localparam int CTL_DIV_HI     = 6;
	localparam int CTL_SINGLE_BIT = 7;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	localparam logic [IDX_W-1:0] REG_IRQ_EN  = 4'd0;
	localparam logic [IDX_W-1:0] REG_IRQ_STA = 4'd1;

	localparam logic [1:0] SUB_CTRL = 2'd0;
	localparam logic [1:0] SUB_INTV = 2'd1;
	localparam logic [1:0] SUB_CUR  = 2'd2;

	typedef logic [COUNTER_BITS-1:0] cnt_t;

	typedef struct packed {
		logic              tick;
		logic              wr_ctrl;
		logic              wr_intv;
		logic              wr_cur;
		logic [DATA_W-1:0] wdata;
	} tmr_cmd_t;

	typedef struct packed {
		logic [CTRL_W-1:0] ctrl;
		cnt_t              intv;
		cnt_t              cur;
		logic              wrap;
	} tmr_view_t;

endpackage

[src/drt_timer.sv]
// One down-counting timer channel: control, interval, current value and prescaler.
module drt_timer (
	input  logic               clk,
	input  logic               arst_n,
	input  drt_pkg::tmr_cmd_t  cmd,
	output drt_pkg::tmr_view_t view
);
	import drt_pkg::*;

	logic [CTRL_W-1:0] ctrl_q;
	cnt_t              intv_q;
	cnt_t              cur_q;
	logic [PSC_W-1:0]  psc_q;

	logic [2:0]       div_sel;
	logic [PSC_W-1:0] psc_lim;
	logic             run;
	logic             step;
	logic             wrap;

	assign div_sel = ctrl_q[CTL_DIV_HI:CTL_DIV_LO];
	assign psc_lim = PSC_W'((8'h01 << div_sel) - 8'h01);
	assign run     = cmd.tick && ctrl_q[CTL_EN_BIT];
	assign step    = run && (psc_q >= psc_lim);
	assign wrap    = step && (cur_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
			intv_q <= '0;
			cur_q  <= '0;
			psc_q  <= '0;
		end else begin
			if (cmd.wr_ctrl) begin
				ctrl_q <= cmd.wdata[CTRL_W-1:0] & ~(CTRL_W'(1) << CTL_RELOAD_BIT);
				if (cmd.wdata[CTL_RELOAD_BIT]) begin
					cur_q <= intv_q;
					psc_q <= '0;
				end
			end
			if (cmd.wr_intv) begin
				intv_q <= cmd.wdata[COUNTER_BITS-1:0];
			end
			if (cmd.wr_cur) begin
				cur_q <= cmd.wdata[COUNTER_BITS-1:0];
			end
			if (run) begin
				if (!step) begin
					psc_q <= psc_q + PSC_W'(1);
				end else begin
					psc_q <= '0;
					if (wrap) begin
						cur_q <= intv_q;
						if (ctrl_q[CTL_SINGLE_BIT]) begin
							ctrl_q[CTL_EN_BIT] <= 1'b0;
						end
					end else begin
						cur_q <= cur_q - COUNTER_BITS'(1);
					end
				end
			end
		end
	end

	assign view.ctrl = ctrl_q;
	assign view.intv = intv_q;
	assign view.cur  = cur_q;
	assign view.wrap = wrap;

endmodule

[src/dual_reload_timer_regs.sv]
// Top level of the dual reload timer register block with stream ports.
// Path: an accepted beat is held in the input register, then loads the result
// register, which drives m_tdata until it is taken.
// Throughput: one beat per cycle while m_tready is high; an input register and a result
// register part the two sides, so s_tready stays high while results drain.
// Reset: arst_n clears all timer, interrupt enable and pending, and handshake registers at once;
// timers come up stopped, continuous, divide by one, with zero counts.
module dual_reload_timer_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata, low bit up: reg_index[3:0], write_value[35:4], zero fill
	input  logic [drt_pkg::S_TDATA_W-1:0] s_tdata,
	// s_tuser, low bit up: operation[1:0]
	input  logic [drt_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata, low bit up: read_value[31:0], irq_timer0[32], irq_timer1[33], zero fill
	output logic [drt_pkg::M_TDATA_W-1:0] m_tdata
);
	import drt_pkg::*;

	// Input stage: hold the accepted beat until the result register takes it.
	logic              valid_s1;
	logic [1:0]        op_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [DATA_W-1:0] wval_s1;

	// Result stage.
	logic              out_valid_q;
	logic [DATA_W-1:0] rd_q;
	logic [1:0]        irq_q;

	// Interrupt enable and pending bits, one per timer slot.
	logic [TIMER_SLOTS-1:0] irq_en_q;
	logic [TIMER_SLOTS-1:0] irq_pend_q;
	logic [TIMER_SLOTS-1:0] irq_en_nx;
	logic [TIMER_SLOTS-1:0] irq_pend_nx;
	logic [TIMER_SLOTS-1:0] tmr_mask;
	logic [TIMER_SLOTS-1:0] wraps;

	logic              adv;
	logic              go;
	logic              is_rd;
	logic              is_wr;
	logic              is_tick;
	logic [DATA_W-1:0] rd_val;

	tmr_cmd_t  cmd  [TIMER_SLOTS];
	tmr_view_t view [TIMER_SLOTS];

	// Advance the result register when it is empty or being taken.
	assign adv      = !out_valid_q || m_tready;
	assign go       = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	assign is_rd   = (op_s1 == OP_READ);
	assign is_wr   = (op_s1 == OP_WRITE);
	assign is_tick = (op_s1 == OP_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser[1:0];
			idx_s1  <= s_tdata[IDX_W-1:0];
			wval_s1 <= s_tdata[IDX_W+DATA_W-1:IDX_W];
		end
	end

	// Timer channels; an absent slot reads as zero and never wraps.
	for (genvar t = 0; t < TIMER_SLOTS; t++) begin : g_tmr
		logic hit;
		assign hit = (idx_s1[3:2] == 2'(t + 1));
		assign tmr_mask[t] = (t < TIMER_COUNT);

		if (t < TIMER_COUNT) begin : g_on
			assign cmd[t].tick    = go && is_tick;
			assign cmd[t].wr_ctrl = go && is_wr && hit && (idx_s1[1:0] == SUB_CTRL);
			assign cmd[t].wr_intv = go && is_wr && hit && (idx_s1[1:0] == SUB_INTV);
			assign cmd[t].wr_cur  = go && is_wr && hit && (idx_s1[1:0] == SUB_CUR);
			assign cmd[t].wdata   = wval_s1;

			drt_timer u_timer (
				.clk    (clk),
				.arst_n (arst_n),
				.cmd    (cmd[t]),
				.view   (view[t])
			);
		end else begin : g_off
			assign cmd[t]  = '0;
			assign view[t] = '0;
		end

		assign wraps[t] = view[t].wrap;
	end

	// Next interrupt bits: irq_sta is write-1-to-clear, wraps set pending.
	always_comb begin
		irq_en_nx   = irq_en_q;
		irq_pend_nx = irq_pend_q | (wraps & tmr_mask);
		if (is_wr && idx_s1 == REG_IRQ_EN) begin
			irq_en_nx = wval_s1[TIMER_SLOTS-1:0] & tmr_mask;
		end
		if (is_wr && idx_s1 == REG_IRQ_STA) begin
			irq_pend_nx = irq_pend_q & ~wval_s1[TIMER_SLOTS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_en_q   <= '0;
			irq_pend_q <= '0;
		end else if (go) begin
			irq_en_q   <= irq_en_nx;
			irq_pend_q <= irq_pend_nx;
		end
	end

	// Read mux; unmapped offsets and absent timers read zero.
	always_comb begin
		rd_val = '0;
		if (is_rd) begin
			if (idx_s1 == REG_IRQ_EN) begin
				rd_val = DATA_W'(irq_en_q);
			end else if (idx_s1 == REG_IRQ_STA) begin
				rd_val = DATA_W'(irq_pend_q);
			end else begin
				for (int t = 0; t < TIMER_SLOTS; t++) begin
					if (idx_s1[3:2] == 2'(t + 1) && tmr_mask[t]) begin
						case (idx_s1[1:0])
							SUB_CTRL: rd_val = DATA_W'(view[t].ctrl);
							SUB_INTV: rd_val = DATA_W'(view[t].intv);
							SUB_CUR:  rd_val = DATA_W'(view[t].cur);
							default:  rd_val = '0;
						endcase
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rd_q  <= rd_val;
			irq_q <= irq_pend_nx & irq_en_nx & tmr_mask;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(M_TDATA_W - DATA_W - 2)'(0), irq_q, rd_q};

endmodule
